// File: rtl/crr_pkg.sv
// Package for the combination rank / unrank core.
// Holds field widths, the stage record handed along the cell chain and the
// saturated Pascal-triangle row function used to build the coefficient ROMs.
package crr_pkg;

  localparam int FIELD_W       = 22;             // width of masks and ranks
  localparam int COUNT_W       = 5;              // width of chosen_count
  localparam int ROW_LEN       = 2 ** COUNT_W;   // coefficients per ROM row
  localparam int COEF_W        = FIELD_W + 1;    // saturated coefficient width
  localparam int MAX_POSITIONS = 50;
  localparam int DEF_POSITIONS = 22;

  // Coefficients at or above 2^FIELD_W are clamped to this value
  localparam logic [COEF_W-1:0] COEF_SAT = COEF_W'(1) << FIELD_W;

  // Operation codes
  localparam logic CMD_RANK   = 1'b0;
  localparam logic CMD_UNRANK = 1'b1;

  typedef logic [ROW_LEN-1:0][COEF_W-1:0] coef_row_t;

  // Work record carried from cell to cell
  typedef struct packed {
    logic               valid;
    logic               cmd;
    logic [FIELD_W-1:0] mask;       // subset mask under rank
    logic [COUNT_W-1:0] k;          // requested chosen count
    logic [FIELD_W-1:0] acc;        // running rank sum, or remaining index
    logic               ovf;        // rank sum left the field
    logic [COUNT_W-1:0] r;          // remaining count
    logic [COUNT_W-1:0] pop;        // chosen positions seen so far
    logic [FIELD_W-1:0] mout;       // mask built by unrank
    logic               range_bad;  // index at or above C(POSITIONS, K)
  } stage_t;

  // Result record at the output register
  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] rank_out;
    logic [FIELD_W-1:0] mask_out;
    logic               bad_request;
  } result_t;

  // Row n of Pascal's triangle, C(n, 0..ROW_LEN-1), clamped at COEF_SAT.
  // Elaboration-time only.
  function automatic coef_row_t pascal_row(input int n);
    coef_row_t         row;
    logic [COEF_W:0]   s;
    row    = '0;
    row[0] = COEF_W'(1);
    for (int m = 1; m <= n; m++) begin
      for (int j = ROW_LEN - 1; j >= 1; j--) begin
        s = {1'b0, row[j]} + {1'b0, row[j-1]};
        row[j] = (s >= {1'b0, COEF_SAT}) ? COEF_SAT : s[COEF_W-1:0];
      end
    end
    return row;
  endfunction

endpackage

// File: rtl/crr_in_if.sv
// Request channel of the combination rank / unrank core.
// Depends on crr_pkg for field widths.
interface crr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [crr_pkg::FIELD_W-1:0] subset_mask;
  logic [crr_pkg::COUNT_W-1:0] chosen_count;
  logic [crr_pkg::FIELD_W-1:0] rank_in;

  modport source (output valid, cmd, subset_mask, chosen_count, rank_in, input ready);
  modport sink   (input valid, cmd, subset_mask, chosen_count, rank_in, output ready);
endinterface

// File: rtl/crr_out_if.sv
// Result channel of the combination rank / unrank core.
// Depends on crr_pkg for field widths.
interface crr_out_if;
  logic                        valid;
  logic                        ready;
  logic [crr_pkg::FIELD_W-1:0] rank_out;
  logic [crr_pkg::FIELD_W-1:0] mask_out;
  logic                        bad_request;

  modport source (output valid, rank_out, mask_out, bad_request, input ready);
  modport sink   (input valid, rank_out, mask_out, bad_request, output ready);
endinterface

// File: rtl/crr_entry.sv
// Entry stage: registers a request and checks the index range for unrank.
// Depends on crr_pkg.
module crr_entry #(
  parameter int POSITIONS = crr_pkg::DEF_POSITIONS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic                        cmd,
  input  logic [crr_pkg::FIELD_W-1:0] subset_mask,
  input  logic [crr_pkg::COUNT_W-1:0] chosen_count,
  input  logic [crr_pkg::FIELD_W-1:0] rank_in,
  output crr_pkg::stage_t             stage
);

  // C(POSITIONS, k) for every k
  localparam crr_pkg::coef_row_t TOP_ROW = crr_pkg::pascal_row(POSITIONS);

  logic [crr_pkg::COEF_W-1:0] limit;
  logic                       out_of_range;

  assign limit        = TOP_ROW[chosen_count];
  assign out_of_range = {1'b0, rank_in} >= limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (adv) begin
      stage.valid <= in_valid;
    end
    if (adv) begin
      stage.cmd       <= cmd;
      stage.mask      <= subset_mask;
      stage.k         <= chosen_count;
      stage.acc       <= (cmd == crr_pkg::CMD_UNRANK) ? rank_in : '0;
      stage.ovf       <= 1'b0;
      stage.r         <= chosen_count;
      stage.pop       <= '0;
      stage.mout      <= '0;
      stage.range_bad <= out_of_range;
    end
  end

endmodule

// File: rtl/crr_cell.sv
// One position of the scan: rank adds or unrank subtracts C(NODE, r).
// Depends on crr_pkg; NODE is the coefficient row, POSITIONS-1-i.
module crr_cell #(
  parameter int NODE = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  crr_pkg::stage_t prev,
  output crr_pkg::stage_t stage
);

  localparam crr_pkg::coef_row_t ROW = crr_pkg::pascal_row(NODE);
  // Positions whose mask bit lies beyond the field read as not chosen
  localparam bit HAS_BIT = NODE < crr_pkg::FIELD_W;
  localparam int BIT     = HAS_BIT ? NODE : 0;

  logic [crr_pkg::COEF_W-1:0] coef;
  logic [crr_pkg::COEF_W-1:0] sum;
  logic                       chosen;
  logic                       take;
  crr_pkg::stage_t            stage_next;

  assign coef   = ROW[prev.r];
  assign chosen = HAS_BIT && prev.mask[BIT];
  assign sum    = {1'b0, prev.acc} + coef;
  assign take   = {1'b0, prev.acc} >= coef;

  always_comb begin
    stage_next = prev;
    if (prev.cmd == crr_pkg::CMD_RANK) begin
      // chosen position: add coefficient, track overflow and count
      if (chosen) begin
        stage_next.acc = sum[crr_pkg::FIELD_W-1:0];
        stage_next.ovf = prev.ovf | sum[crr_pkg::FIELD_W];
        stage_next.r   = prev.r - crr_pkg::COUNT_W'(1);
        stage_next.pop = prev.pop + crr_pkg::COUNT_W'(1);
      end
    end else begin
      // index covers the coefficient: choose this position
      if (take) begin
        if (HAS_BIT) begin
          stage_next.mout[BIT] = 1'b1;
        end
        stage_next.acc = prev.acc - coef[crr_pkg::FIELD_W-1:0];
        if (prev.r != '0) begin
          stage_next.r = prev.r - crr_pkg::COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (adv) begin
      stage.valid <= prev.valid;
    end
    if (adv) begin
      stage.cmd       <= stage_next.cmd;
      stage.mask      <= stage_next.mask;
      stage.k         <= stage_next.k;
      stage.acc       <= stage_next.acc;
      stage.ovf       <= stage_next.ovf;
      stage.r         <= stage_next.r;
      stage.pop       <= stage_next.pop;
      stage.mout      <= stage_next.mout;
      stage.range_bad <= stage_next.range_bad;
    end
  end

endmodule

// File: rtl/crr_result.sv
// Output register: forms rank_out, mask_out and bad_request from the last cell.
// Depends on crr_pkg.
module crr_result (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  crr_pkg::stage_t  last,
  output crr_pkg::result_t res
);

  logic bad;

  // rank fails on a count mismatch or a sum past the field; unrank on range_bad
  assign bad = (last.cmd == crr_pkg::CMD_RANK) ? ((last.pop != last.k) || last.ovf)
                                               : last.range_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res.valid <= last.valid;
    end
    if (adv) begin
      res.bad_request <= bad;
      res.rank_out    <= (last.cmd == crr_pkg::CMD_RANK && !bad) ? last.acc : '0;
      res.mask_out    <= (last.cmd == crr_pkg::CMD_UNRANK && !bad) ? last.mout : '0;
    end
  end

endmodule

// File: rtl/combination_rank_unrank_core.sv
// Combination rank / unrank core.
//
// Request channel (req): cmd selects rank of subset_mask against
// chosen_count, or unrank of rank_in into a chosen_count-of-POSITIONS
// subset. Position i sits at mask bit POSITIONS-1-i. Result channel (rsp)
// carries rank_out, mask_out and bad_request; the field not asked for is 0,
// and both are 0 when bad_request is set.
//
// A transaction passes an entry register, one cell per position and an
// output register on its way to rsp.valid.
// Throughput is one transaction per cycle unless rsp stalls; each cell holds
// its own Pascal-row ROM and adder/comparator logic, so nothing is shared.
//
// Reset (rst, synchronous) clears all valid flags; no clearing pass.
// When rsp is stalled with a result waiting, the whole chain holds and
// req.ready drops in the same cycle; it returns as soon as rsp.ready rises.
// Each transaction yields exactly one result, in order.
module combination_rank_unrank_core #(
  parameter int POSITIONS = crr_pkg::DEF_POSITIONS
) (
  input logic  clk,
  input logic  rst,
  crr_in_if.sink    req,
  crr_out_if.source rsp
);

  crr_pkg::stage_t  chain [POSITIONS+1];
  crr_pkg::result_t res;
  logic             adv;

  // chain moves whenever the output slot is free or being drained
  assign adv       = !res.valid || rsp.ready;
  assign req.ready = adv;

  crr_entry #(
    .POSITIONS (POSITIONS)
  ) u_entry (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (req.valid),
    .cmd          (req.cmd),
    .subset_mask  (req.subset_mask),
    .chosen_count (req.chosen_count),
    .rank_in      (req.rank_in),
    .stage        (chain[0])
  );

  // one cell per position, first position first
  for (genvar i = 0; i < POSITIONS; i++) begin : g_cell
    crr_cell #(
      .NODE (POSITIONS - 1 - i)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .adv   (adv),
      .prev  (chain[i]),
      .stage (chain[i+1])
    );
  end

  crr_result u_result (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .last (chain[POSITIONS]),
    .res  (res)
  );

  assign rsp.valid       = res.valid;
  assign rsp.rank_out    = res.rank_out;
  assign rsp.mask_out    = res.mask_out;
  assign rsp.bad_request = res.bad_request;

endmodule

// File: sim/combination_rank_unrank_core_tb.sv
// Self-checking testbench for combination_rank_unrank_core at POSITIONS = 22.
// Depends on crr_pkg, crr_in_if and crr_out_if. The first rows come from a
// fixed table and random bursts follow. Every result is checked in order.
module combination_rank_unrank_core_tb;

  localparam int N            = crr_pkg::DEF_POSITIONS;
  localparam int ITEM_TARGET  = 600;
  localparam int DRAIN_CYCLES = N + 12;
  localparam longint unsigned FIELD_MAX = (64'd1 << crr_pkg::FIELD_W) - 64'd1;

  typedef struct packed {
    logic [crr_pkg::FIELD_W-1:0] rank;
    logic [crr_pkg::FIELD_W-1:0] mask;
    logic                        bad;
  } rr_result_t;

  typedef struct packed {
    logic                        cmd;
    logic [crr_pkg::FIELD_W-1:0] mask;
    logic [crr_pkg::COUNT_W-1:0] k;
    logic [crr_pkg::FIELD_W-1:0] idx;
    logic                        typed;  // want holds a hand-written expectation
    rr_result_t                  want;
  } rr_request_t;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  rr_result_t  results_due[$];

  crr_in_if  req_if ();
  crr_out_if rsp_if ();

  combination_rank_unrank_core #(.POSITIONS(N)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Edge cases first: extremes, wrong counts, indexes just out of range
  rr_request_t directed_rows [20] = '{
    '{crr_pkg::CMD_RANK,   22'h000000, 5'd0,  22'd0,      1'b1, '{22'd0, 22'd0, 1'b0}},
    '{crr_pkg::CMD_RANK,   22'h3FFFFF, 5'd22, 22'h3FFFFF, 1'b1, '{22'd0, 22'd0, 1'b0}},
    '{crr_pkg::CMD_RANK,   22'h3FFFFF, 5'd21, 22'd0,      1'b1, '{22'd0, 22'd0, 1'b1}},
    '{crr_pkg::CMD_RANK,   22'h000001, 5'd0,  22'd0,      1'b1, '{22'd0, 22'd0, 1'b1}},
    '{crr_pkg::CMD_RANK,   22'h3FFFFF, 5'd31, 22'd0,      1'b1, '{22'd0, 22'd0, 1'b1}},
    '{crr_pkg::CMD_RANK,   22'h3FF800, 5'd11, 22'd0,      1'b0, '0},
    '{crr_pkg::CMD_RANK,   22'h0007FF, 5'd11, 22'd0,      1'b0, '0},
    '{crr_pkg::CMD_RANK,   22'h200000, 5'd1,  22'd0,      1'b0, '0},
    '{crr_pkg::CMD_RANK,   22'h000001, 5'd1,  22'd0,      1'b0, '0},
    '{crr_pkg::CMD_RANK,   22'h2AAAAA, 5'd11, 22'h155555, 1'b0, '0},
    '{crr_pkg::CMD_UNRANK, 22'h3FFFFF, 5'd0,  22'd0,      1'b1, '{22'd0, 22'd0, 1'b0}},
    '{crr_pkg::CMD_UNRANK, 22'h000000, 5'd0,  22'd1,      1'b1, '{22'd0, 22'd0, 1'b1}},
    '{crr_pkg::CMD_UNRANK, 22'h000000, 5'd22, 22'd0,      1'b1, '{22'd0, 22'h3FFFFF, 1'b0}},
    '{crr_pkg::CMD_UNRANK, 22'h000000, 5'd22, 22'd1,      1'b1, '{22'd0, 22'd0, 1'b1}},
    '{crr_pkg::CMD_UNRANK, 22'h000000, 5'd31, 22'h3FFFFF, 1'b1, '{22'd0, 22'd0, 1'b1}},
    '{crr_pkg::CMD_UNRANK, 22'h000000, 5'd11, 22'd705431, 1'b0, '0},
    '{crr_pkg::CMD_UNRANK, 22'h000000, 5'd11, 22'd705432, 1'b1, '{22'd0, 22'd0, 1'b1}},
    '{crr_pkg::CMD_UNRANK, 22'h155555, 5'd1,  22'd21,     1'b0, '0},
    '{crr_pkg::CMD_UNRANK, 22'h000000, 5'd1,  22'd0,      1'b0, '0},
    '{crr_pkg::CMD_UNRANK, 22'h000000, 5'd22, 22'h3FFFFF, 1'b1, '{22'd0, 22'd0, 1'b1}}
  };

  // Exact C(n, r), 0 when r > n
  function automatic longint unsigned binomial(input int n, input int r);
    longint unsigned c;
    int              rr;
    if (r < 0 || r > n) return 0;
    rr = (r > n - r) ? n - r : r;
    c  = 1;
    for (int j = 0; j < rr; j++) c = c * longint'(n - j) / longint'(j + 1);
    return c;
  endfunction

  // Rank of a subset mask, or subset for an index, with the request checks
  function automatic rr_result_t combination_result(
      input logic                        cmd,
      input logic [crr_pkg::FIELD_W-1:0] mask,
      input logic [crr_pkg::COUNT_W-1:0] k,
      input logic [crr_pkg::FIELD_W-1:0] idx);
    rr_result_t      res;
    longint unsigned sum;
    longint unsigned rest;
    longint unsigned c;
    int              r;
    int              pop;
    int              b;
    int              i;
    res = '0;
    if (cmd == crr_pkg::CMD_RANK) begin
      pop = 0;
      for (i = 0; i < N; i++) begin
        b = N - 1 - i;
        if (b < crr_pkg::FIELD_W && mask[b]) pop++;
      end
      if (pop != int'(k)) begin
        res.bad = 1'b1;
      end else begin
        sum = 0;
        r   = int'(k);
        for (i = 0; i < N; i++) begin
          b = N - 1 - i;
          if (b < crr_pkg::FIELD_W && mask[b]) begin
            sum += binomial(N - 1 - i, r);
            r--;
          end
        end
        if (sum > FIELD_MAX) res.bad = 1'b1;
        else res.rank = sum[crr_pkg::FIELD_W-1:0];
      end
    end else begin
      rest = longint'(idx);
      if (rest >= binomial(N, int'(k))) begin
        res.bad = 1'b1;
      end else begin
        r = int'(k);
        for (i = 0; i < N; i++) begin
          c = binomial(N - 1 - i, r);
          if (rest >= c) begin
            b = N - 1 - i;
            if (b < crr_pkg::FIELD_W) res.mask[b] = 1'b1;
            rest -= c;
            if (r > 0) r--;
          end
        end
      end
    end
    return res;
  endfunction

  // Mostly valid requests with random content; the rest is noise
  function automatic rr_request_t random_request();
    rr_request_t     q;
    int              kk;
    int              pos;
    int              placed;
    longint unsigned span;
    q      = '0;
    q.cmd  = 1'($urandom_range(0, 1));
    q.mask = crr_pkg::FIELD_W'($urandom);
    q.idx  = crr_pkg::FIELD_W'($urandom);
    if ($urandom_range(0, 9) < 8) begin
      kk  = $urandom_range(0, N);
      q.k = crr_pkg::COUNT_W'(kk);
      if (q.cmd == crr_pkg::CMD_RANK) begin
        q.mask = '0;
        placed = 0;
        while (placed < kk) begin
          pos = $urandom_range(0, N - 1);
          if (!q.mask[pos]) begin
            q.mask[pos] = 1'b1;
            placed++;
          end
        end
      end else begin
        span = binomial(N, kk);
        if ($urandom_range(0, 7) == 0) q.idx = crr_pkg::FIELD_W'(span - 1);
        else q.idx = crr_pkg::FIELD_W'(longint'($urandom) % span);
      end
    end else begin
      q.k = crr_pkg::COUNT_W'($urandom_range(0, 31));
      // count off by one now and then
      if (q.cmd == crr_pkg::CMD_RANK && $urandom_range(0, 1) == 1)
        q.k = crr_pkg::COUNT_W'($countones(q.mask) + $urandom_range(0, 2) - 1);
    end
    return q;
  endfunction

  // Drive one transaction and log its expectation once accepted
  task automatic send_request(input rr_request_t q);
    @(negedge clk);
    req_if.valid        <= 1'b1;
    req_if.cmd          <= q.cmd;
    req_if.subset_mask  <= q.mask;
    req_if.chosen_count <= q.k;
    req_if.rank_in      <= q.idx;
    do @(posedge clk); while (!req_if.ready);
    results_due.push_back(q.typed ? q.want : combination_result(q.cmd, q.mask, q.k, q.idx));
  endtask

  task automatic pause_requests(input int cycles);
    @(negedge clk);
    req_if.valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Receiver stall pattern: open, light, heavy, periodic
  always @(negedge clk) begin
    cycle_count <= cycle_count + 1;
    case ((cycle_count / 150) % 4)
      0:       rsp_if.ready <= 1'b1;
      1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
      2:       rsp_if.ready <= ($urandom_range(0, 1) != 0);
      default: rsp_if.ready <= ((cycle_count % 9) >= 3);
    endcase
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    rr_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (results_due.size() == 0) begin
        $error("result with no request outstanding: rank_out %0d mask_out %06h bad %0b",
               rsp_if.rank_out, rsp_if.mask_out, rsp_if.bad_request);
        error_count++;
      end else begin
        want = results_due.pop_front();
        if (rsp_if.rank_out !== want.rank) begin
          $error("rank_out expected %0d actual %0d", want.rank, rsp_if.rank_out);
          error_count++;
        end
        if (rsp_if.mask_out !== want.mask) begin
          $error("mask_out expected %06h actual %06h", want.mask, rsp_if.mask_out);
          error_count++;
        end
        if (rsp_if.bad_request !== want.bad) begin
          $error("bad_request expected %0b actual %0b", want.bad, rsp_if.bad_request);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int sent;
    int burst;
    rst                 = 1'b1;
    req_if.valid        = 1'b0;
    req_if.cmd          = crr_pkg::CMD_RANK;
    req_if.subset_mask  = '0;
    req_if.chosen_count = '0;
    req_if.rank_in      = '0;
    rsp_if.ready        = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Random bursts with gaps; halfway the sender waits for the pipe to empty
    sent = 0;
    while (sent < ITEM_TARGET) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < ITEM_TARGET) begin
        send_request(random_request());
        sent++;
        burst--;
        if (sent == ITEM_TARGET / 2) begin
          pause_requests(1);
          while (results_due.size() != 0) @(posedge clk);
        end
      end
      if ($urandom_range(0, 3) != 0) pause_requests($urandom_range(1, 12));
    end
    pause_requests(1);

    // Drain, then watch for stray results
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
